/* hw/rtl/aaht_pkg.sv */
// Shared types, codes and defaults of the aging address hash table.
package aaht_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int BUCKETS_DEF = 32;
    localparam logic [31:0] INTERVAL_RESET = 32'd60;
    localparam int OCC_W = 9;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_PURGE = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] address;
        logic [31:0] current_time;
    } in_word_t;

    typedef struct packed {
        logic             hit;
        logic             accepted;
        logic [OCC_W-1:0] occupancy;
        logic [31:0]      hits_total;
        logic [31:0]      misses_total;
    } out_word_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] address;
        logic [31:0] current_time;
        logic [31:0] interval;
        logic        refresh;
    } cmd_t;

    typedef struct packed {
        logic        valid;
        logic        found;
        logic        placed;
        logic [31:0] best_stamp;
    } carry_t;

endpackage

/* hw/rtl/aaht_hash.sv */
// Iterative one-at-a-time hash of a 32-bit address, reduced to a bucket number.
module aaht_hash #(
    parameter int BUCKETS = aaht_pkg::BUCKETS_DEF,
    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      key,
    output logic             done,
    output logic [BKT_W-1:0] bucket
);
    import aaht_pkg::*;

    localparam logic [2:0] BYTE_STEPS = 3'd4;
    localparam logic [2:0] LAST_STEP = 3'd5;
    localparam logic [BKT_W-1:0] BKT_MASK = BKT_W'(BUCKETS - 1);

    logic        running_reg, running_next;
    logic        done_reg, done_next;
    logic [2:0]  step_reg, step_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] t1, t2;

    always_comb
    begin
        running_next = running_reg;
        done_next = 1'b0;
        step_next = step_reg;
        key_next = key_reg;
        h_next = h_reg;
        t1 = '0;
        t2 = '0;
        if (start)
        begin
            running_next = 1'b1;
            step_next = '0;
            key_next = key;
            h_next = '0;
        end
        else if (running_reg)
        begin
            if (step_reg < BYTE_STEPS)
            begin
                t1 = h_reg + {24'd0, key_reg[7:0]};
                t2 = t1 + (t1 << 10);
                h_next = t2 ^ (t2 >> 6);
                key_next = key_reg >> 8;
            end
            else if (step_reg == BYTE_STEPS)
            begin
                t1 = h_reg + (h_reg << 3);
                h_next = t1 ^ (t1 >> 11);
            end
            else
            begin
                h_next = h_reg + (h_reg << 15);
            end
            step_next = step_reg + 3'd1;
            if (step_reg == LAST_STEP)
            begin
                running_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        h_reg <= h_next;
    end

    assign done = done_reg;
    assign bucket = h_reg[BKT_W-1:0] & BKT_MASK;

endmodule

/* hw/rtl/aaht_cell.sv */
// One table entry with its share of the scan wave that steps along the row.
module aaht_cell #(
    parameter int CAPACITY = aaht_pkg::CAPACITY_DEF,
    parameter int BUCKETS = aaht_pkg::BUCKETS_DEF,
    parameter int INDEX = 0,
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  aaht_pkg::cmd_t    cmd,
    input  logic [BKT_W-1:0]  cmd_tag,
    input  logic [IDX_W-1:0]  refresh_idx,
    input  aaht_pkg::carry_t  carry_in,
    input  logic [IDX_W-1:0]  idx_in,
    input  logic [CNT_W-1:0]  freed_in,
    output aaht_pkg::carry_t  carry_out,
    output logic [IDX_W-1:0]  idx_out,
    output logic [CNT_W-1:0]  freed_out
);
    import aaht_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic             used_reg, used_next;
    logic [31:0]      addr_reg, addr_next;
    logic [31:0]      stamp_reg, stamp_next;
    logic [BKT_W-1:0] tag_reg, tag_next;
    carry_t           carry_reg, carry_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] freed_reg, freed_next;
    logic             expired;
    logic             in_bucket;

    assign expired = ({1'b0, stamp_reg} + {1'b0, cmd.interval}) < {1'b0, cmd.current_time};
    assign in_bucket = used_reg && (tag_reg == cmd_tag);

    always_comb
    begin
        used_next = used_reg;
        addr_next = addr_reg;
        stamp_next = stamp_reg;
        tag_next = tag_reg;
        carry_next = carry_in;
        idx_next = idx_in;
        freed_next = freed_in;
        if (carry_in.valid)
        begin
            unique case (cmd.action)
                ACT_LOOKUP:
                begin
                    if (in_bucket)
                    begin
                        if (expired)
                        begin
                            used_next = 1'b0;
                            freed_next = CNT_W'(freed_in + 1'b1);
                        end
                        else if ((addr_reg == cmd.address) &&
                                 (!carry_in.found || (stamp_reg < carry_in.best_stamp)))
                        begin
                            carry_next.found = 1'b1;
                            carry_next.best_stamp = stamp_reg;
                            idx_next = MY_IDX;
                        end
                    end
                end
                ACT_INSERT:
                begin
                    if (!used_reg && !carry_in.placed)
                    begin
                        used_next = 1'b1;
                        addr_next = cmd.address;
                        stamp_next = cmd.current_time;
                        tag_next = cmd_tag;
                        carry_next.placed = 1'b1;
                    end
                end
                ACT_PURGE:
                begin
                    if (used_reg && expired)
                    begin
                        used_next = 1'b0;
                        freed_next = CNT_W'(freed_in + 1'b1);
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.refresh && (refresh_idx == MY_IDX))
        begin
            stamp_next = cmd.current_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        stamp_reg <= stamp_next;
        tag_reg <= tag_next;
        idx_reg <= idx_next;
        freed_reg <= freed_next;
    end

    assign carry_out = carry_reg;
    assign idx_out = idx_reg;
    assign freed_out = freed_reg;

endmodule

/* hw/rtl/aging_address_hash_table.sv */
// Top level of the aging address hash table: command control and the row of entry cells.
//
// Each command word (lookup, insert, purge or any other action code) is
// answered once it has passed the hash, the scan of the row and the result
// register. The address is first hashed one byte per step and then finished
// by the final mixing steps. The bucket is then latched and a wave is launched
// that steps through the row of entry cells one cell per cycle. The result is
// then registered, and while it is shown the matched stamp is refreshed. busy
// stays high from the accepting edge through the result cycle, so a new word
// is taken only after the previous result has been shown. The result stays
// on the result port until the next one; done marks it for exactly one cycle,
// and the receiver cannot stall it. Writes to the expiry interval are taken
// at any time, but should only be made while busy is low.
module aging_address_hash_table #(
    parameter int CAPACITY = aaht_pkg::CAPACITY_DEF,
    parameter int BUCKETS = aaht_pkg::BUCKETS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  aaht_pkg::in_word_t  request,
    output logic                busy,
    output logic                done,
    output aaht_pkg::out_word_t result,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata
);
    import aaht_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HASH = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             launch_reg, launch_next;
    logic [31:0]      interval_reg;
    logic [1:0]       action_reg, action_next;
    logic [31:0]      address_reg, address_next;
    logic [31:0]      time_reg, time_next;
    logic [BKT_W-1:0] tag_reg, tag_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      hits_reg, hits_next;
    logic [31:0]      misses_reg, misses_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    out_word_t        result_reg, result_next;

    logic             accept;
    logic             hash_done;
    logic [BKT_W-1:0] hash_bucket;
    cmd_t             cmd;
    carry_t           carry_end;
    logic             is_lookup;

    carry_t           carry_chain [CAPACITY+1];
    logic [IDX_W-1:0] idx_chain [CAPACITY+1];
    logic [CNT_W-1:0] freed_chain [CAPACITY+1];

    assign accept = start && (state_reg == ST_IDLE);
    assign carry_end = carry_chain[CAPACITY];
    assign is_lookup = (action_reg == ACT_LOOKUP);

    aaht_hash #(
        .BUCKETS(BUCKETS)
    ) u_hash (
        .clk(clk),
        .rst_n(rst_n),
        .start(accept),
        .key(request.address),
        .done(hash_done),
        .bucket(hash_bucket)
    );

    always_comb
    begin
        cmd.action = action_reg;
        cmd.address = address_reg;
        cmd.current_time = time_reg;
        cmd.interval = interval_reg;
        cmd.refresh = (state_reg == ST_DONE) && result_reg.hit;
    end

    assign carry_chain[0] = '{valid: launch_reg, found: 1'b0, placed: 1'b0, best_stamp: 32'd0};
    assign idx_chain[0] = '0;
    assign freed_chain[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        aaht_cell #(
            .CAPACITY(CAPACITY),
            .BUCKETS(BUCKETS),
            .INDEX(g)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .cmd(cmd),
            .cmd_tag(tag_reg),
            .refresh_idx(best_idx_reg),
            .carry_in(carry_chain[g]),
            .idx_in(idx_chain[g]),
            .freed_in(freed_chain[g]),
            .carry_out(carry_chain[g+1]),
            .idx_out(idx_chain[g+1]),
            .freed_out(freed_chain[g+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        launch_next = 1'b0;
        action_next = action_reg;
        address_next = address_reg;
        time_next = time_reg;
        tag_next = tag_reg;
        count_next = count_reg;
        hits_next = hits_reg;
        misses_next = misses_reg;
        best_idx_next = best_idx_reg;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    action_next = request.action;
                    address_next = request.address;
                    time_next = request.current_time;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    tag_next = hash_bucket;
                    launch_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (carry_end.valid)
                begin
                    count_next = CNT_W'(count_reg - freed_chain[CAPACITY] +
                                        CNT_W'(carry_end.placed));
                    if (is_lookup && carry_end.found)
                    begin
                        hits_next = hits_reg + 32'd1;
                    end
                    else if (is_lookup)
                    begin
                        misses_next = misses_reg + 32'd1;
                    end
                    best_idx_next = idx_chain[CAPACITY];
                    result_next.hit = is_lookup && carry_end.found;
                    result_next.accepted = (action_reg == ACT_INSERT) && carry_end.placed;
                    result_next.occupancy = OCC_W'(count_next);
                    result_next.hits_total = hits_next;
                    result_next.misses_total = misses_next;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            launch_reg <= 1'b0;
            interval_reg <= INTERVAL_RESET;
            count_reg <= '0;
            hits_reg <= '0;
            misses_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            launch_reg <= launch_next;
            if (cfg_we)
            begin
                interval_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            hits_reg <= hits_next;
            misses_reg <= misses_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        address_reg <= address_next;
        time_reg <= time_next;
        tag_reg <= tag_next;
        best_idx_reg <= best_idx_next;
        result_reg <= result_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);
    assign result = result_reg;

endmodule

/* hw/rtl/aaht_checker.sv */
// Port-level checks of the aging address hash table and their binding to the top level.
module aaht_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input aaht_pkg::out_word_t result
);
    import aaht_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("Accepted command word did not raise busy.");

    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("Result word shown while not busy.");

    a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("Block did not return to idle after a result word.");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.hit && result.accepted))
        else $error("Result word marks both a hit and an accepted insert.");

endmodule

bind aging_address_hash_table aaht_checker u_aaht_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .result(result)
);

/* verif/tb_top.sv */
// Self-checking testbench of the aging address hash table: command words, expiry, refresh and counters.
module tb_top;
    import aaht_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int NBUCKET = BUCKETS_DEF;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PRINT_CAP = 100;

    logic        clk;
    logic        rst_n;
    logic        start;
    in_word_t    request;
    logic        busy;
    logic        done;
    out_word_t   result;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    logic [31:0] ent_addr [CAP];
    logic [31:0] ent_stamp [CAP];
    int          ent_bucket [CAP];
    bit          ent_used [CAP];
    int unsigned occ_count;
    logic [31:0] hit_cnt;
    logic [31:0] miss_cnt;
    logic [31:0] live_interval;

    out_word_t   due_replies [$];
    out_word_t   want;
    logic [31:0] hot_addrs [24];
    int          err_count = 0;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;

    aging_address_hash_table #(
        .CAPACITY(CAP),
        .BUCKETS(NBUCKET)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .request(request),
        .busy(busy),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int jenkins_bucket(logic [31:0] a);
        logic [31:0] h;
        int k;
        h = '0;
        for (k = 0; k < 4; k++)
        begin
            h += {24'd0, a[8*k +: 8]};
            h += h << 10;
            h ^= h >> 6;
        end
        h += h << 3;
        h ^= h >> 11;
        h += h << 15;
        return int'(h & (NBUCKET - 1));
    endfunction

    function automatic bit is_stale(logic [31:0] stamp, logic [31:0] now);
        logic [32:0] limit;
        limit = {1'b0, stamp} + {1'b0, live_interval};
        return limit < {1'b0, now};
    endfunction

    function automatic void drop_entry(int i);
        ent_used[i] = 1'b0;
        if (occ_count > 0)
            occ_count--;
    endfunction

    function automatic out_word_t age_table_apply(in_word_t w);
        out_word_t r;
        int b;
        int i;
        int best;
        bit found;
        r = '0;
        found = 1'b0;
        best = 0;
        case (w.action)
            ACT_LOOKUP:
            begin
                b = jenkins_bucket(w.address);
                for (i = 0; i < CAP; i++)
                begin
                    if (ent_used[i] && ent_bucket[i] == b)
                    begin
                        if (is_stale(ent_stamp[i], w.current_time))
                            drop_entry(i);
                        else if (ent_addr[i] == w.address &&
                                 (!found || ent_stamp[i] < ent_stamp[best]))
                        begin
                            found = 1'b1;
                            best = i;
                        end
                    end
                end
                if (found)
                begin
                    ent_stamp[best] = w.current_time;
                    hit_cnt++;
                    r.hit = 1'b1;
                end
                else
                    miss_cnt++;
            end
            ACT_INSERT:
            begin
                for (i = 0; i < CAP && !r.accepted; i++)
                begin
                    if (!ent_used[i])
                    begin
                        ent_used[i] = 1'b1;
                        ent_addr[i] = w.address;
                        ent_stamp[i] = w.current_time;
                        ent_bucket[i] = jenkins_bucket(w.address);
                        occ_count++;
                        r.accepted = 1'b1;
                    end
                end
            end
            ACT_PURGE:
            begin
                for (i = 0; i < CAP; i++)
                    if (ent_used[i] && is_stale(ent_stamp[i], w.current_time))
                        drop_entry(i);
            end
            default:
            begin
            end
        endcase
        r.occupancy = occ_count[OCC_W-1:0];
        r.hits_total = hit_cnt;
        r.misses_total = miss_cnt;
        return r;
    endfunction

    function automatic in_word_t make_word(logic [1:0] act, logic [31:0] a, logic [31:0] t);
        in_word_t w;
        w.action = act;
        w.address = a;
        w.current_time = t;
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < PRINT_CAP)
            $display("ERROR cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    task automatic wait_all_replies();
        while (due_replies.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_interval(input logic [31:0] v);
        wait_all_replies();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        live_interval = v;
    endtask

    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < sender_idle_pct)
            @(negedge clk);
        @(negedge clk);
        start <= 1'b1;
        request <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        due_replies.push_back(age_table_apply(w));
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic test_directed();
        send_word(make_word(ACT_LOOKUP, 32'h0000_0000, 32'd0));
        send_word(make_word(ACT_INSERT, 32'h0000_0000, 32'd0));
        send_word(make_word(ACT_INSERT, 32'hFFFF_FFFF, 32'd0));
        send_word(make_word(ACT_LOOKUP, 32'hFFFF_FFFF, 32'd60));
        send_word(make_word(ACT_LOOKUP, 32'h0000_0000, 32'd61));
        send_word(make_word(ACT_INSERT, 32'h1234_5678, 32'd100));
        send_word(make_word(ACT_INSERT, 32'h1234_5678, 32'd110));
        send_word(make_word(ACT_LOOKUP, 32'h1234_5678, 32'd120));
        send_word(make_word(ACT_LOOKUP, 32'h1234_5678, 32'd125));
        send_word(make_word(ACT_NONE, 32'hA5A5_A5A5, 32'd130));
        send_word(make_word(ACT_LOOKUP, 32'h1234_5678, 32'd50));
        send_word(make_word(ACT_PURGE, 32'h5A5A_5A5A, 32'd175));
        send_word(make_word(ACT_INSERT, 32'h0000_00FF, 32'd200));
        send_word(make_word(ACT_INSERT, 32'h0000_FF00, 32'd200));
        send_word(make_word(ACT_INSERT, 32'h00FF_0000, 32'd200));
        send_word(make_word(ACT_INSERT, 32'hFF00_0000, 32'd200));
        send_word(make_word(ACT_LOOKUP, 32'h00FF_0000, 32'd260));
        send_word(make_word(ACT_INSERT, 32'h8000_0000, 32'h8000_0000));
        send_word(make_word(ACT_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF));
        send_word(make_word(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(make_word(ACT_PURGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(make_word(ACT_LOOKUP, 32'hFF00_0000, 32'hFFFF_FFFF));
    endtask

    task automatic test_interval_extremes();
        write_interval(32'd0);
        send_word(make_word(ACT_INSERT, 32'hC0DE_0001, 32'd1000));
        send_word(make_word(ACT_LOOKUP, 32'hC0DE_0001, 32'd1000));
        send_word(make_word(ACT_LOOKUP, 32'hC0DE_0001, 32'd1001));
        write_interval(32'hFFFF_FFFF);
        send_word(make_word(ACT_INSERT, 32'hC0DE_0002, 32'd0));
        send_word(make_word(ACT_LOOKUP, 32'hC0DE_0002, 32'hFFFF_FFFF));
        send_word(make_word(ACT_PURGE, 32'd0, 32'hFFFF_FFFF));
        write_interval(32'd1);
        send_word(make_word(ACT_PURGE, 32'd0, 32'hFFFF_FFFF));
    endtask

    task automatic test_full_pool();
        logic [31:0] kept [4];
        logic [31:0] a;
        logic [31:0] t0;
        int k;
        write_interval(32'd1000);
        t0 = 32'd5000;
        for (k = 0; k < CAP + 3; k++)
        begin
            a = $urandom;
            if (k < 4)
                kept[k] = a;
            send_word(make_word(ACT_INSERT, a, t0 + k));
        end
        for (k = 0; k < 4; k++)
            send_word(make_word(ACT_LOOKUP, kept[k], t0 + 300));
        send_word(make_word(ACT_PURGE, $urandom, t0 + 2000));
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input logic [31:0] iv);
        logic [31:0] a;
        logic [31:0] now;
        in_word_t w;
        int k;
        int roll;
        int pick;
        write_interval(iv);
        sender_idle_pct = idle_pct;
        for (k = 0; k < 24; k++)
        begin
            a = $urandom;
            while (k < 8 && jenkins_bucket(a) != 0)
                a = $urandom;
            hot_addrs[k] = a;
        end
        send_word(make_word(ACT_PURGE, $urandom, 32'hFFFF_FFFF));
        now = $urandom;
        for (k = 0; k < n_items; k++)
        begin
            if (k == n_items / 2)
                wait_all_replies();
            roll = $urandom_range(99);
            if (roll < 3)
                now = now - $urandom_range(40, 1);
            else if (roll < 6)
                now = now + 2 * iv + $urandom_range(100, 1);
            else
                now = now + $urandom_range(iv / 8 + 1, 0);
            a = hot_addrs[$urandom_range(23)];
            pick = $urandom_range(99);
            if (pick < 10)
                w = make_word(2'($urandom_range(3)), $urandom, now);
            else if (pick < 55)
                w = make_word(ACT_LOOKUP, a, now);
            else if (pick < 82)
                w = make_word(ACT_INSERT, a, now);
            else if (pick < 94)
                w = make_word(ACT_PURGE, a, now);
            else
                w = make_word(ACT_NONE, a, now);
            send_word(w);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (due_replies.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                want = due_replies.pop_front();
                if (result.hit !== want.hit)
                    report_mismatch($sformatf("hit %0b, expected %0b", result.hit, want.hit));
                if (result.accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %0b, expected %0b",
                                              result.accepted, want.accepted));
                if (result.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, expected %0d",
                                              result.occupancy, want.occupancy));
                if (result.hits_total !== want.hits_total)
                    report_mismatch($sformatf("hits_total %0d, expected %0d",
                                              result.hits_total, want.hits_total));
                if (result.misses_total !== want.misses_total)
                    report_mismatch($sformatf("misses_total %0d, expected %0d",
                                              result.misses_total, want.misses_total));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        live_interval = INTERVAL_RESET;
        occ_count = 0;
        hit_cnt = '0;
        miss_cnt = '0;
        for (i = 0; i < CAP; i++)
        begin
            ent_addr[i] = '0;
            ent_stamp[i] = '0;
            ent_bucket[i] = 0;
            ent_used[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 34;
        test_directed();
        test_interval_extremes();
        test_full_pool();
        test_random_traffic(370, 34, 32'd60);
        test_random_traffic(370, 63, 32'($urandom_range(400, 100)));
        test_random_traffic(370, 0, 32'd3);

        wait_all_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_replies.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", due_replies.size()));
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/aaht_pkg.sv
hw/rtl/aaht_hash.sv
hw/rtl/aaht_cell.sv
hw/rtl/aging_address_hash_table.sv
hw/rtl/aaht_checker.sv
verif/tb_top.sv
